@@ src/art_pkg.sv @@
`timescale 1ns / 1ps

package art_pkg;

	// Default segment limits.
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int AUTO_SEGMENTS_PER_TURN_DEF = 64;
	localparam int MIN_AUTO_SEGMENTS_DEF = 8;

	// Field widths.
	localparam int COORD_W = 16;
	localparam int ANGLE_W = 17;
	localparam int WANT_W = 8;
	localparam int COLOR_W = 32;

	// Radians Q5.12 to turns Q0.16, round(2^32 / (2*pi*4096)).
	localparam logic [17:0] PHASE_MUL = 18'd166886;

	// Quarter-wave sine polynomial coefficients.
	localparam logic [11:0] SIN_C1 = 12'd2320;
	localparam logic [14:0] SIN_C2 = 15'd21024;
	localparam logic [15:0] SIN_C3 = 16'd51472;

	// One divider iteration per sweep magnitude bit.
	localparam int DIV_STEPS = 17;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SETUP,
		OP_DIV,
		OP_PHASE,
		OP_ZSEL,
		OP_SQ,
		OP_P1,
		OP_P2,
		OP_P3,
		OP_CMUL,
		OP_CADD,
		OP_EMIT,
		OP_STEP
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SETUP,
		S_DIV,
		S_PHASE,
		S_ZSEL,
		S_SQ,
		S_P1,
		S_P2,
		S_P3,
		S_CMUL,
		S_CADD,
		S_EMIT,
		S_STEP
	} state_t;

	typedef struct packed {
		op_t        op;
		logic       trig_sel;    // 0: cosine, 1: sine
		logic [1:0] corner_sel;  // bit 0: y, bit 1: outer radius
	} cmd_t;

	typedef struct packed {
		logic degen;
		logic first_pt;
		logic last_pt;
		logic out_free;
	} status_t;

endpackage

@@ src/arc_ring_tessellator.sv @@
`timescale 1ns / 1ps
// The first quad leaves once the first two points of the arc are computed and the output is free.
// An arc of n segments has n+1 points; each point runs one shared sine polynomial twice and
// one corner multiplier four times. A new arc is taken only after the last quad of the previous one.
// A degenerate arc is dropped in the check state, which returns to idle.
// Reset is asynchronous and active low; it empties the output register and idles the block.

module arc_ring_tessellator
	import art_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int AUTO_SEGMENTS_PER_TURN = AUTO_SEGMENTS_PER_TURN_DEF,
	parameter int MIN_AUTO_SEGMENTS = MIN_AUTO_SEGMENTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// center_x, center_y, mid_radius, ring_thickness, start_angle, sweep_angle,
	// segments_wanted, color_rgba, zero fill
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// inner_start_x, inner_start_y, outer_start_x, outer_start_y, outer_end_x,
	// outer_end_y, inner_end_x, inner_end_y, quad_color
	output logic [159:0] m_tdata,
	output logic         m_tlast
);

	cmd_t    cmd;
	status_t status;

	// Sequencer for one arc.
	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Angle, trigonometry and corner arithmetic.
	art_dp #(
		.MAX_SEGMENTS           (MAX_SEGMENTS),
		.AUTO_SEGMENTS_PER_TURN (AUTO_SEGMENTS_PER_TURN),
		.MIN_AUTO_SEGMENTS      (MIN_AUTO_SEGMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

@@ src/art_ctrl.sv @@
`timescale 1ns / 1ps

module art_ctrl
	import art_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t     state_q, state_d;
	logic [4:0] div_cnt_q;
	logic       ts_q;
	logic [1:0] cs_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_CHECK;
			S_CHECK: state_d = status.degen ? S_IDLE : S_SETUP;
			S_SETUP: state_d = S_DIV;
			S_DIV:   if (div_cnt_q == 5'(DIV_STEPS - 1)) state_d = S_PHASE;
			S_PHASE: state_d = S_ZSEL;
			S_ZSEL:  state_d = S_SQ;
			S_SQ:    state_d = S_P1;
			S_P1:    state_d = S_P2;
			S_P2:    state_d = S_P3;
			S_P3:    state_d = ts_q ? S_CMUL : S_ZSEL;
			S_CMUL:  state_d = S_CADD;
			S_CADD: begin
				if (cs_q != 2'd3) state_d = S_CMUL;
				else if (status.first_pt) state_d = S_STEP;
				else state_d = S_EMIT;
			end
			S_EMIT:  if (status.out_free) state_d = status.last_pt ? S_IDLE : S_STEP;
			S_STEP:  state_d = S_PHASE;
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.trig_sel = ts_q;
		cmd.corner_sel = cs_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_CHECK: cmd.op = OP_NONE;
			S_SETUP: cmd.op = OP_SETUP;
			S_DIV:   cmd.op = OP_DIV;
			S_PHASE: cmd.op = OP_PHASE;
			S_ZSEL:  cmd.op = OP_ZSEL;
			S_SQ:    cmd.op = OP_SQ;
			S_P1:    cmd.op = OP_P1;
			S_P2:    cmd.op = OP_P2;
			S_P3:    cmd.op = OP_P3;
			S_CMUL:  cmd.op = OP_CMUL;
			S_CADD:  cmd.op = OP_CADD;
			S_EMIT:  if (status.out_free) cmd.op = OP_EMIT;
			S_STEP:  cmd.op = OP_STEP;
			default: cmd.op = OP_NONE;
		endcase
	end

	// State and sequencing counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_cnt_q <= '0;
			ts_q <= 1'b0;
			cs_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SETUP) div_cnt_q <= '0;
			else if (state_q == S_DIV) div_cnt_q <= div_cnt_q + 5'd1;
			if (state_q == S_PHASE) ts_q <= 1'b0;
			else if (state_q == S_P3) ts_q <= 1'b1;
			if (state_q == S_P3) cs_q <= '0;
			else if (state_q == S_CADD) cs_q <= cs_q + 2'd1;
		end
	end

endmodule

@@ src/art_dp.sv @@
`timescale 1ns / 1ps

module art_dp
	import art_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int AUTO_SEGMENTS_PER_TURN = AUTO_SEGMENTS_PER_TURN_DEF,
	parameter int MIN_AUTO_SEGMENTS = MIN_AUTO_SEGMENTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cmd_t           cmd,
	output status_t        status,
	input  logic [143:0]   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [159:0]   out_data,
	output logic           out_last
);

	localparam int NW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [24:0] AUTO_MUL = 25'(AUTO_SEGMENTS_PER_TURN * 166886);

	// Item registers.
	logic signed [15:0] cx_q, cy_q, rad_q, thk_q;
	logic signed [16:0] start_q, sweep_q;
	logic [7:0]         want_q;
	logic [31:0]        color_q;

	logic [NW-1:0]      n_q, k_q, dr_q, racc_q;
	logic [16:0]        dq_q, qacc_q;
	logic [15:0]        inner_q;
	logic [16:0]        outer_q;
	logic [15:0]        p_q;
	logic [14:0]        z_q, z2_q;
	logic               neg_q;
	logic [15:0]        t_q;
	logic signed [17:0] cos_q, sin_q;
	logic signed [35:0] cprod_q;
	logic [15:0]        cur_q [4];
	logic [15:0]        prev_q [4];
	logic               ov_q;

	// Sweep magnitude.
	logic [16:0] in_mag, mag;
	assign in_mag = in_data[97] ? (~in_data[97:81] + 17'd1) : in_data[97:81];
	assign mag = sweep_q[16] ? (~sweep_q + 17'd1) : sweep_q;

	// Segment count and radii.
	logic [41:0]    auto_prod;
	logic [9:0]     auto_cnt;
	logic [NW-1:0]  n_d;
	logic signed [16:0] half, outer_v, inner_v;
	assign auto_prod = 42'(mag) * 42'(AUTO_MUL);
	assign auto_cnt = auto_prod[41:32];
	always_comb begin
		if (want_q == '0) begin
			if (auto_cnt < 10'(MIN_AUTO_SEGMENTS)) n_d = NW'(MIN_AUTO_SEGMENTS);
			else if (auto_cnt > 10'(MAX_SEGMENTS)) n_d = NW'(MAX_SEGMENTS);
			else n_d = NW'(auto_cnt);
		end else begin
			if (9'(want_q) > 9'(MAX_SEGMENTS)) n_d = NW'(MAX_SEGMENTS);
			else n_d = NW'(want_q);
		end
	end
	assign half = 17'(thk_q >>> 1);
	assign outer_v = 17'(rad_q) + half;
	assign inner_v = 17'(rad_q) - half;

	// One restoring division step of |sweep| by n.
	logic [NW:0] trial;
	logic        trial_ge;
	assign trial = {dr_q, dq_q[16]};
	assign trial_ge = trial >= {1'b0, n_q};

	// Remainder accumulation for the next angle.
	logic [NW:0] rsum;
	logic        rsum_ge;
	assign rsum = {1'b0, racc_q} + {1'b0, dr_q};
	assign rsum_ge = rsum >= {1'b0, n_q};

	// Angle to turn phase.
	logic signed [18:0] angle;
	logic signed [37:0] ph_prod;
	logic [31:0]        ph_sum;
	assign angle = 19'(start_q) + (sweep_q[16] ? -$signed({2'b00, qacc_q}) : $signed({2'b00, qacc_q}));
	assign ph_prod = angle * $signed({1'b0, PHASE_MUL});
	assign ph_sum = ph_prod[31:0] + 32'd32768;

	// Quarter-wave selection.
	logic [15:0] pp;
	assign pp = cmd.trig_sel ? p_q : (p_q + 16'd16384);

	// Polynomial products.
	logic [29:0] sq_prod;
	logic [26:0] m1;
	logic [14:0] c2d;
	logic [29:0] m2;
	logic [30:0] m3;
	logic signed [17:0] s_val;
	assign sq_prod = 30'(z_q) * 30'(z_q);
	assign m1 = 27'(SIN_C1) * 27'(z2_q);
	assign c2d = SIN_C2 - 15'(t_q);
	assign m2 = 30'(c2d) * 30'(z2_q);
	assign m3 = 31'(t_q) * 31'(z_q);
	assign s_val = neg_q ? -$signed({1'b0, m3[30:14]}) : $signed({1'b0, m3[30:14]});

	// Corner product and saturated add.
	logic signed [17:0] trig_v, rad_v;
	logic signed [20:0] off;
	logic signed [21:0] csum;
	logic [15:0]        csat;
	assign trig_v = cmd.corner_sel[0] ? sin_q : cos_q;
	assign rad_v = cmd.corner_sel[1] ? $signed({1'b0, outer_q}) : $signed({2'b00, inner_q});
	assign off = 21'(cprod_q >>> 15);
	assign csum = 22'(cmd.corner_sel[0] ? cy_q : cx_q) + 22'(off);
	always_comb begin
		if (csum > 22'sd32767) csat = 16'h7FFF;
		else if (csum < -22'sd32768) csat = 16'h8000;
		else csat = csum[15:0];
	end

	// Status for the controller.
	assign status.degen = (rad_q <= 0) || (thk_q <= 0) || (sweep_q == '0);
	assign status.first_pt = (k_q == '0);
	assign status.last_pt = (k_q == n_q);
	assign status.out_free = !ov_q || out_ready;

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cx_q <= in_data[15:0];
				cy_q <= in_data[31:16];
				rad_q <= in_data[47:32];
				thk_q <= in_data[63:48];
				start_q <= in_data[80:64];
				sweep_q <= in_data[97:81];
				want_q <= in_data[105:98];
				color_q <= in_data[137:106];
				dq_q <= in_mag;
				dr_q <= '0;
				qacc_q <= '0;
				racc_q <= '0;
				k_q <= '0;
			end
			OP_SETUP: begin
				n_q <= n_d;
				outer_q <= outer_v;
				inner_q <= inner_v[16] ? 16'd0 : inner_v[15:0];
			end
			OP_DIV: begin
				dq_q <= {dq_q[15:0], trial_ge};
				dr_q <= trial_ge ? NW'(trial - {1'b0, n_q}) : NW'(trial);
			end
			OP_PHASE: p_q <= ph_sum[31:16];
			OP_ZSEL: begin
				z_q <= pp[14] ? (15'd16384 - {1'b0, pp[13:0]}) : {1'b0, pp[13:0]};
				neg_q <= pp[15];
			end
			OP_SQ: z2_q <= sq_prod[28:14];
			OP_P1: t_q <= 16'(m1[26:14]);
			OP_P2: t_q <= SIN_C3 - m2[29:14];
			OP_P3: begin
				if (cmd.trig_sel) sin_q <= s_val;
				else cos_q <= s_val;
			end
			OP_CMUL: cprod_q <= trig_v * rad_v + 36'sd16384;
			OP_CADD: cur_q[cmd.corner_sel] <= csat;
			OP_STEP: begin
				for (int j = 0; j < 4; j++) prev_q[j] <= cur_q[j];
				k_q <= k_q + NW'(1);
				if (rsum_ge) begin
					racc_q <= NW'(rsum - {1'b0, n_q});
					qacc_q <= qacc_q + dq_q + 17'd1;
				end else begin
					racc_q <= NW'(rsum);
					qacc_q <= qacc_q + dq_q;
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_data <= {color_q, cur_q[1], cur_q[0], cur_q[3], cur_q[2],
				prev_q[3], prev_q[2], prev_q[1], prev_q[0]};
			out_last <= status.last_pt;
		end
	end

	assign out_valid = ov_q;

endmodule

@@ dv/arc_ring_checker.sv @@
`timescale 1ns / 1ps

module arc_ring_checker
	import art_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [159:0] m_tdata,
	input  logic         m_tlast,
	output int           fail_count,
	output int           quads_pending,
	output int           quads_seen,
	output int           arcs_drawn
);

	// One predicted quad: corners and color packed as on m_tdata, plus the last flag.
	typedef struct {
		logic [159:0] data;
		logic         last;
	} quad_t;

	quad_t quad_q[$];

	// Radians Q5.12 to phase in 1/65536 turns.
	function automatic logic [15:0] turn_phase(input longint ang);
		longint v;
		v = ang * 166886 + 32768;
		return v[31:16];
	endfunction

	// Quarter-wave sine polynomial, Q1.15.
	function automatic int quarter_wave(input int z);
		int z2;
		int t;
		z2 = (z * z) >>> 14;
		t = (2320 * z2) >>> 14;
		t = ((21024 - t) * z2) >>> 14;
		t = 51472 - t;
		return (t * z) >>> 14;
	endfunction

	function automatic int sine_of(input logic [15:0] p);
		int x;
		x = p[13:0];
		case (p[15:14])
			2'd0: return quarter_wave(x);
			2'd1: return quarter_wave(16384 - x);
			2'd2: return -quarter_wave(x);
			default: return -quarter_wave(16384 - x);
		endcase
	endfunction

	// Center plus rounded trig-scaled radius, saturated to 16 bits.
	function automatic logic [15:0] ring_corner(input longint c, input int trig,
			input longint r);
		longint v;
		v = c + ((longint'(trig) * r + 16384) >>> 15);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// Expand one accepted arc into its predicted quads.
	task automatic predict_arc(input logic [143:0] d);
		longint cx, cy, rad, thk, st, sw, half, outr, innr, mag, a0, a1, n;
		int want, c0, s0, c1, s1;
		logic [15:0] p0, p1;
		quad_t q;
		cx = $signed(d[15:0]);
		cy = $signed(d[31:16]);
		rad = $signed(d[47:32]);
		thk = $signed(d[63:48]);
		st = $signed(d[80:64]);
		sw = $signed(d[97:81]);
		want = d[105:98];
		if (rad <= 0 || thk <= 0 || sw == 0) return;
		if (want == 0) begin
			mag = (sw < 0) ? -sw : sw;
			n = (mag * AUTO_SEGMENTS_PER_TURN_DEF * 166886) >>> 32;
			if (n < MIN_AUTO_SEGMENTS_DEF) n = MIN_AUTO_SEGMENTS_DEF;
		end else begin
			n = want;
		end
		if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
		half = thk / 2;
		outr = rad + half;
		innr = rad - half;
		if (innr < 0) innr = 0;
		for (longint i = 0; i < n; i++) begin
			a0 = st + (sw * i) / n;
			a1 = st + (sw * (i + 1)) / n;
			p0 = turn_phase(a0);
			p1 = turn_phase(a1);
			c0 = sine_of(p0 + 16'd16384);
			s0 = sine_of(p0);
			c1 = sine_of(p1 + 16'd16384);
			s1 = sine_of(p1);
			q.data = {d[137:106],
				ring_corner(cy, s1, innr), ring_corner(cx, c1, innr),
				ring_corner(cy, s1, outr), ring_corner(cx, c1, outr),
				ring_corner(cy, s0, outr), ring_corner(cx, c0, outr),
				ring_corner(cy, s0, innr), ring_corner(cx, c0, innr)};
			q.last = (i + 1 == n);
			quad_q.insert(quad_q.size(), q);
		end
		arcs_drawn++;
	endtask

	initial begin
		fail_count = 0;
		quads_pending = 0;
		quads_seen = 0;
		arcs_drawn = 0;
	end

	// Watch both channels at each rising edge.
	always @(posedge clk) begin
		quad_t exp_q;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				quads_seen++;
				if (quad_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected quad %h last %b", $time, m_tdata, m_tlast);
				end else begin
					exp_q = quad_q.pop_front();
					for (int f = 0; f < 9; f++) begin
						if (f < 8 && m_tdata[f*16 +: 16] !== exp_q.data[f*16 +: 16]) begin
							fail_count++;
							$display("%0t: corner field %0d expected %h actual %h", $time, f,
								exp_q.data[f*16 +: 16], m_tdata[f*16 +: 16]);
						end
					end
					if (m_tdata[159:128] !== exp_q.data[159:128]) begin
						fail_count++;
						$display("%0t: color expected %h actual %h", $time,
							exp_q.data[159:128], m_tdata[159:128]);
					end
					if (m_tlast !== exp_q.last) begin
						fail_count++;
						$display("%0t: last expected %b actual %b", $time, exp_q.last, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) predict_arc(s_tdata);
			quads_pending = quad_q.size();
		end
	end

endmodule

@@ dv/arc_ring_tessellator_tb.sv @@
`timescale 1ns / 1ps

module arc_ring_tessellator_tb;
	import art_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// center_x, center_y, mid_radius, ring_thickness, start_angle, sweep_angle,
	// segments_wanted, color_rgba, zero fill
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// inner_start_x, inner_start_y, outer_start_x, outer_start_y, outer_end_x,
	// outer_end_y, inner_end_x, inner_end_y, quad_color
	logic [159:0] m_tdata;
	logic         m_tlast;
	int           fail_count;
	int           quads_pending;
	int           quads_seen;
	int           arcs_drawn;
	int           send_idle_pct;
	int           recv_idle_pct;

	arc_ring_tessellator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	arc_ring_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .quads_pending(quads_pending),
		.quads_seen(quads_seen), .arcs_drawn(arcs_drawn)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random at each falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Send one arc request and hold it until it is taken. Valid stays high after
	// the handshake so that a following request can start at the same falling edge.
	task automatic send_arc(input logic [15:0] cx, input logic [15:0] cy,
			input logic [15:0] rad, input logic [15:0] thk, input logic [16:0] st,
			input logic [16:0] sw, input logic [7:0] want, input logic [31:0] color);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		s_tdata <= {6'd0, color, want, sw, st, thk, rad, cy, cx};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random arc, mostly well formed with small segment counts.
	task automatic random_arc();
		logic [15:0] rad, thk;
		logic [16:0] sw;
		logic [7:0] want;
		int pick;
		pick = $urandom_range(99);
		rad = (pick < 60) ? 16'($urandom_range(1, 4000)) : 16'($urandom);
		thk = (pick < 60) ? 16'($urandom_range(1, 2000)) : 16'($urandom);
		sw = 17'($urandom);
		if ($urandom_range(9) == 0) sw = 17'd0;
		case ($urandom_range(9))
			0: want = 8'd0;
			1: want = 8'($urandom);
			2: want = 8'd64;
			default: want = 8'($urandom_range(1, 12));
		endcase
		send_arc(16'($urandom), 16'($urandom), rad, thk, 17'($urandom), sw, want,
			$urandom);
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 68;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed arcs: degenerate forms, extremes, odd thickness, saturation.
		send_arc(16'd0, 16'd0, 16'd0, 16'd16, 17'd0, 17'd6434, 8'd4, 32'h11223344);
		send_arc(16'd0, 16'd0, 16'd160, 16'd0, 17'd0, 17'd6434, 8'd4, 32'h0);
		send_arc(16'd0, 16'd0, 16'd160, 16'd16, 17'd0, 17'd0, 8'd4, 32'h0);
		send_arc(16'h8000, 16'h8000, 16'h8000, 16'h8000, 17'h10000, 17'h10000, 8'd0,
			32'h0);
		send_arc(16'd100, 16'd200, 16'd160, 16'd33, 17'd0, 17'd25736, 8'd0, 32'hFFFFFFFF);
		send_arc(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 17'h0FFFF, 17'h0FFFF, 8'hFF,
			32'hA5A5A5A5);
		send_arc(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 17'h10000, 17'h10000, 8'd1,
			32'h5A5A5A5A);
		send_arc(16'd0, 16'd0, 16'd8, 16'd40, 17'h1F000, 17'h1E6DE, 8'd3, 32'h12345678);
		send_arc(16'd0, 16'd0, 16'd1, 16'd1, 17'd0, 17'd1, 8'd0, 32'h87654321);
		send_arc(16'hFFFF, 16'hFFFF, 16'd1000, 16'd2, 17'd12000, 17'h1FFFF, 8'd65,
			32'h0F0F0F0F);
		send_arc(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 17'h0AAAA, 17'h15555, 8'd2,
			32'hF0F0F0F0);

		for (int k = 0; k < 370; k++) begin
			if (k == 124) begin
				send_idle_pct = 68;
				recv_idle_pct = 16;
			end else if (k == 248) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_arc();
		end
		s_tvalid <= 1'b0;

		while (quads_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent 381 arcs; %0d drew quads, %0d quads checked.", arcs_drawn,
			quads_seen);
		$display("Covered degenerate arcs, automatic and saturated counts, three stall mixes.");
		if (fail_count == 0 && quads_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
src/art_pkg.sv
src/art_ctrl.sv
src/art_dp.sv
src/arc_ring_tessellator.sv
dv/arc_ring_checker.sv
dv/arc_ring_tessellator_tb.sv
